>>> sv/sorted_key_value_table_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted key/value table: assertion macros
// Shared assertion forms for the table, clocked on clk with rst_n masking.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define SKVT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key/value table check failed");

// Next-cycle implication.
`define SKVT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key/value table check failed");

`endif

>>> sv/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Sizes, codes and shared types of the table and its entry memory.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    // Signed search bounds: one more bit so the upper bound can reach -1.
    localparam int IDX_W    = CNT_W + 1;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_FIND = 2'd1;
    localparam logic [1:0] ACT_DEL  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_RESERVED  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_POS   = 3'd4;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

endpackage

>>> sv/skvt_ram.sv
// ----------------------------------------------------------------------------
// Sorted key/value table entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skvt_ram (
    input  logic                          clk,
    input  skvt_pkg::ram_wr_t             wr,
    input  logic [skvt_pkg::ADDR_W-1:0]   raddr,
    output skvt_pkg::entry_t              rdata
);
    import skvt_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sorted_key_value_table_top.sv
// ----------------------------------------------------------------------------
// Sorted key/value table
// Keeps key/value pairs in ascending key order in one entry memory.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one command per transfer: s_tuser holds the action
// (add, find, delete) and s_tdata holds key, value and position. The master
// channel returns exactly one result per command: m_tuser holds the status and
// m_tdata holds the found value, found position and the entry count after the
// command.
// A find is a binary search; each probe issues a read of the entry memory in
// S_FRD and compares the probed key in S_FCMP. An add first searches for
// the slot after the last equal key (at most log2(CAPACITY) probes), then moves
// every later entry up by one place at one entry per cycle and writes the new
// pair. A delete moves the later entries down at one entry per cycle. Refused
// commands go from S_IDLE straight to S_RESP. The single write and single
// read port of the entry memory set these move rates. Commands are handled
// one at a time.
// Reset clears the entry count and the control state; the memory contents are
// not cleared, and entries beyond the count are never used. A finished result
// sits in the output register, so the next command is accepted while the
// receiver stalls; the block only waits when a second result is ready before
// the first one has been taken.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_top_defines.svh"

module sorted_key_value_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key[31:0], value[63:32], position[71:64]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_value[31:0], found_position[39:32],
                                   // entry_count[48:40], zero fill above
    output logic [2:0]  m_tuser    // status[2:0]
);
    import skvt_pkg::*;

    // One-hot control states.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FRD    = 8'b0000_0010,   // find: issue probe read
        S_FCMP   = 8'b0000_0100,   // find: compare probed key
        S_URD    = 8'b0000_1000,   // add: issue upper-bound probe read
        S_UCMP   = 8'b0001_0000,   // add: compare probed key
        S_ASHIFT = 8'b0010_0000,   // add: move entries up, then write pair
        S_DSHIFT = 8'b0100_0000,   // delete: move entries down
        S_RESP   = 8'b1000_0000    // load the result register
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_count_reg, fill_count_next;
    logic signed [IDX_W-1:0]  lo_reg, lo_next;
    logic signed [IDX_W-1:0]  hi_reg, hi_next;
    logic signed [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic [ADDR_W-1:0]        rd_addr_reg, rd_addr_next;
    logic                     rd_v_reg, rd_v_next;
    logic [31:0]              key_reg, key_next;
    logic [31:0]              value_reg, value_next;
    logic [2:0]               status_reg, status_next;
    logic [31:0]              fval_reg, fval_next;
    logic [ADDR_W-1:0]        fpos_reg, fpos_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [2:0]               out_status_reg, out_status_next;
    logic [31:0]              out_fval_reg, out_fval_next;
    logic [7:0]               out_fpos_reg, out_fpos_next;
    logic [8:0]               out_count_reg, out_count_next;

    ram_wr_t                  wr;
    logic [ADDR_W-1:0]        raddr;
    entry_t                   rdata;

    logic                     accept;
    logic [1:0]               in_action;
    logic [31:0]              in_key;
    logic [31:0]              in_value;
    logic [7:0]               in_pos;
    logic signed [IDX_W-1:0]  mid_full;
    logic signed [IDX_W-1:0]  ptr_m1;
    logic signed [IDX_W-1:0]  fill_s;
    logic                     issue;

    skvt_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_key    = s_tdata[31:0];
    assign in_value  = s_tdata[63:32];
    assign in_pos    = s_tdata[71:64];
    assign in_action = s_tuser;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Probe point of the current search window.
    assign mid_full = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign ptr_m1   = ptr_reg - IDX_W'(1);
    assign fill_s   = IDX_W'(fill_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        mid_next        = mid_reg;
        rd_addr_next    = rd_addr_reg;
        rd_v_next       = 1'b0;
        key_next        = key_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        fval_next       = fval_reg;
        fpos_next       = fpos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_fval_next   = out_fval_reg;
        out_fpos_next   = out_fpos_reg;
        out_count_next  = out_count_reg;
        raddr           = mid_full[ADDR_W-1:0];
        wr.we           = 1'b0;
        wr.addr         = rd_addr_reg;
        wr.data         = rdata;
        issue           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = in_key;
                    value_next  = in_value;
                    status_next = ST_OK;
                    fval_next   = '0;
                    fpos_next   = '0;
                    state_next  = S_RESP;
                    case (in_action)
                        ACT_ADD:
                        begin
                            if (fill_count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (in_key == '1)
                            begin
                                status_next = ST_RESERVED;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = fill_s;
                                state_next = S_URD;
                            end
                        end
                        ACT_FIND:
                        begin
                            lo_next    = '0;
                            hi_next    = fill_s - IDX_W'(1);
                            state_next = S_FRD;
                        end
                        ACT_DEL:
                        begin
                            if (CNT_W'(in_pos) >= fill_count_reg)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(in_pos) + IDX_W'(1);
                                state_next = S_DSHIFT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_FRD:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid_full[ADDR_W-1:0];
                    state_next = S_FCMP;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
            end

            S_FCMP:
            begin
                if (rdata.key < key_reg)
                begin
                    lo_next    = IDX_W'(mid_reg) + IDX_W'(1);
                    state_next = S_FRD;
                end
                else if (rdata.key > key_reg)
                begin
                    hi_next    = IDX_W'(mid_reg) - IDX_W'(1);
                    state_next = S_FRD;
                end
                else
                begin
                    fval_next  = rdata.value;
                    fpos_next  = mid_reg;
                    state_next = S_RESP;
                end
            end

            S_URD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_full[ADDR_W-1:0];
                    state_next = S_UCMP;
                end
                else
                begin
                    // lo_reg now holds the insertion slot.
                    ptr_next   = fill_s;
                    state_next = S_ASHIFT;
                end
            end

            S_UCMP:
            begin
                if (rdata.key <= key_reg)
                begin
                    lo_next = IDX_W'(mid_reg) + IDX_W'(1);
                end
                else
                begin
                    hi_next = IDX_W'(mid_reg);
                end
                state_next = S_URD;
            end

            S_ASHIFT:
            begin
                issue = (ptr_reg > lo_reg);
                raddr = ptr_m1[ADDR_W-1:0];
                if (issue)
                begin
                    ptr_next     = ptr_m1;
                    rd_addr_next = ptr_m1[ADDR_W-1:0];
                    rd_v_next    = 1'b1;
                end
                if (rd_v_reg)
                begin
                    wr.we   = 1'b1;
                    wr.addr = rd_addr_reg + ADDR_W'(1);
                end
                else if (!issue)
                begin
                    wr.we           = 1'b1;
                    wr.addr         = lo_reg[ADDR_W-1:0];
                    wr.data.key     = key_reg;
                    wr.data.value   = value_reg;
                    fill_count_next = fill_count_reg + CNT_W'(1);
                    state_next      = S_RESP;
                end
            end

            S_DSHIFT:
            begin
                issue = (ptr_reg < fill_s);
                raddr = ptr_reg[ADDR_W-1:0];
                if (issue)
                begin
                    ptr_next     = ptr_reg + IDX_W'(1);
                    rd_addr_next = ptr_reg[ADDR_W-1:0];
                    rd_v_next    = 1'b1;
                end
                if (rd_v_reg)
                begin
                    wr.we   = 1'b1;
                    wr.addr = rd_addr_reg - ADDR_W'(1);
                end
                else if (!issue)
                begin
                    fill_count_next = fill_count_reg - CNT_W'(1);
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                // Wait only if the previous result is still held.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = status_reg;
                    out_fval_next   = fval_reg;
                    out_fpos_next   = 8'(fpos_reg);
                    out_count_next  = 9'(fill_count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            rd_v_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_v_reg       <= rd_v_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        ptr_reg        <= ptr_next;
        mid_reg        <= mid_next;
        rd_addr_reg    <= rd_addr_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
        fval_reg       <= fval_next;
        fpos_reg       <= fpos_next;
        out_status_reg <= out_status_next;
        out_fval_reg   <= out_fval_next;
        out_fpos_reg   <= out_fpos_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_fpos_reg, out_fval_reg};

    // The entry count never exceeds the table capacity.
    `SKVT_ASSERT_NOW(a_count_bound, 1'b1, fill_count_reg <= CNT_W'(CAPACITY))

    // Entry writes happen only while entries are being moved or inserted.
    `SKVT_ASSERT_NOW(a_write_state, wr.we,
        (state_reg == S_ASHIFT) || (state_reg == S_DSHIFT))

    // A write never lands beyond the entry just past the filled region.
    `SKVT_ASSERT_NOW(a_write_range, wr.we, CNT_W'(wr.addr) <= fill_count_reg)

    // A result is handed over as soon as the output register is free.
    `SKVT_ASSERT_NEXT(a_resp_drain, (state_reg == S_RESP) && (!m_tvalid_reg || m_tready),
        (state_reg == S_IDLE) && m_tvalid_reg)

endmodule

>>> bench/sorted_key_value_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key/value table testbench
// Drives add, find, delete and ignored-action commands into the table over the
// slave stream and compares every result on the master stream with a software
// copy of the sorted table that the scoreboard keeps. Both sides idle at random.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top_test;

    import skvt_pkg::*;

    // The fourth action code does nothing in the table but still answers.
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    localparam int RANDOM_CMDS   = 1750;
    localparam int SEGMENT_CMDS  = 350;
    // An add into a full-length move is the slowest command.
    localparam int DRAIN_CYCLES  = 300;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [7:0]  found_position;
        logic [8:0]  entry_count;
    } table_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own sorted table and the results still owed.
    // ------------------------------------------------------------------------
    class table_scoreboard;
        logic [31:0]   keys [CAPACITY];
        logic [31:0]   values [CAPACITY];
        int            fill;
        table_result_t owed [$];
        int            mismatches;
        int            adds, finds, deletes, ignored;
        int            full_refusals, reserved_refusals, hits, misses, bad_positions;
        int            peak_fill;

        function new();
            fill = 0;
            mismatches = 0;
            adds = 0;
            finds = 0;
            deletes = 0;
            ignored = 0;
            full_refusals = 0;
            reserved_refusals = 0;
            hits = 0;
            misses = 0;
            bad_positions = 0;
            peak_fill = 0;
        endfunction

        // Applies one accepted command to the table copy and records its result.
        function void note_command(logic [1:0] act, logic [31:0] k, logic [31:0] v,
                                   logic [7:0] p);
            table_result_t r;
            int            slot;
            int            lo;
            int            hi;
            int            mid;
            int            i;
            bit            found;
            r = '0;
            r.status = ST_OK;
            case (act)
                ACT_ADD:
                begin
                    adds++;
                    if (fill >= CAPACITY)
                    begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end
                    else if (k == 32'hFFFF_FFFF)
                    begin
                        r.status = ST_RESERVED;
                        reserved_refusals++;
                    end
                    else
                    begin
                        // The new pair goes after the last entry with an equal key.
                        slot = 0;
                        while (slot < fill && keys[slot] <= k)
                            slot++;
                        for (i = fill; i > slot; i--)
                        begin
                            keys[i]   = keys[i-1];
                            values[i] = values[i-1];
                        end
                        keys[slot]   = k;
                        values[slot] = v;
                        fill++;
                        if (fill > peak_fill)
                            peak_fill = fill;
                    end
                end
                ACT_FIND:
                begin
                    finds++;
                    lo = 0;
                    hi = fill - 1;
                    found = 1'b0;
                    while (lo <= hi && !found)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (keys[mid] < k)
                            lo = mid + 1;
                        else if (keys[mid] > k)
                            hi = mid - 1;
                        else
                        begin
                            found = 1'b1;
                            r.found_value    = values[mid];
                            r.found_position = 8'(mid);
                        end
                    end
                    if (found)
                        hits++;
                    else
                    begin
                        r.status = ST_NOT_FOUND;
                        misses++;
                    end
                end
                ACT_DEL:
                begin
                    deletes++;
                    if (int'(p) >= fill)
                    begin
                        r.status = ST_BAD_POS;
                        bad_positions++;
                    end
                    else
                    begin
                        for (i = int'(p); i < fill - 1; i++)
                        begin
                            keys[i]   = keys[i+1];
                            values[i] = values[i+1];
                        end
                        fill--;
                    end
                end
                default:
                    ignored++;
            endcase
            r.entry_count = 9'(fill);
            owed.push_back(r);
        endfunction

        function void check_result(table_result_t got);
            table_result_t exp;
            if (owed.size() == 0)
            begin
                $error("result transfer arrived with no command outstanding");
                mismatches++;
                return;
            end
            exp = owed.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                mismatches++;
            end
            if (got.found_value !== exp.found_value)
            begin
                $error("found_value: expected %h, actual %h",
                       exp.found_value, got.found_value);
                mismatches++;
            end
            if (got.found_position !== exp.found_position)
            begin
                $error("found_position: expected %0d, actual %0d",
                       exp.found_position, got.found_position);
                mismatches++;
            end
            if (got.entry_count !== exp.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d",
                       exp.entry_count, got.entry_count);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;    // key[31:0], value[63:32], position[71:64]
    logic [1:0]  s_tuser = '0;    // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // found_value[31:0], found_position[39:32],
                                  // entry_count[48:40], zero fill above
    logic [2:0]  m_tuser;         // status[2:0]

    table_scoreboard sb = new();
    int              send_idle_pct = 37;
    int              recv_idle_pct = 47;
    int              quiet_cycles = 0;

    sorted_key_value_table_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Results are taken from the values that were stable before the edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result({m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[48:40]});
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_command(input logic [1:0] act, input logic [31:0] k,
                                input logic [31:0] v, input logic [7:0] p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {p, v, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(act, k, v, p);
    endtask

    // Keys lean toward ones already stored and a narrow range, so that
    // duplicates and successful finds are common.
    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && sb.fill > 0)
            return sb.keys[$urandom_range(0, sb.fill - 1)];
        if (sel < 70)
            return 32'($urandom_range(0, 63));
        if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'hFFFF_FFFE;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [7:0] pick_position();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80 && sb.fill > 0)
            return 8'($urandom_range(0, sb.fill - 1));
        if (sel < 90)
            return 8'(sb.fill);
        return 8'($urandom_range(0, 255));
    endfunction

    // Segments cycle through filling the table, a mixed load, draining it,
    // and a mixed load again.
    task automatic send_random_command(input int index);
        int         roll;
        int         add_pct;
        int         find_pct;
        int         del_pct;
        logic [1:0] act;
        roll = $urandom_range(0, 99);
        case ((index / SEGMENT_CMDS) % 4)
            0:       begin add_pct = 80; find_pct = 10; del_pct = 7;  end
            2:       begin add_pct = 8;  find_pct = 10; del_pct = 80; end
            default: begin add_pct = 40; find_pct = 35; del_pct = 22; end
        endcase
        if (roll < add_pct)
            act = ACT_ADD;
        else if (roll < add_pct + find_pct)
            act = ACT_FIND;
        else if (roll < add_pct + find_pct + del_pct)
            act = ACT_DEL;
        else
            act = ACT_IGNORED;
        send_command(act, pick_key(), $urandom(), pick_position());
    endtask

    task automatic run_directed();
        send_command(ACT_FIND,    32'h0000_0005, 32'h0,         8'd0);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd0);
        send_command(ACT_IGNORED, 32'h1234_5678, 32'h9ABC_DEF0, 8'd17);
        send_command(ACT_ADD,     32'hFFFF_FFFF, 32'h1111_1111, 8'd0);
        send_command(ACT_ADD,     32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        send_command(ACT_ADD,     32'hFFFF_FFFE, 32'h0000_0000, 8'd255);
        // Three entries with one key: each lands after the previous one.
        send_command(ACT_ADD,     32'h0000_0005, 32'hAAAA_0001, 8'd0);
        send_command(ACT_ADD,     32'h0000_0005, 32'hAAAA_0002, 8'd0);
        send_command(ACT_ADD,     32'h0000_0005, 32'hAAAA_0003, 8'd0);
        send_command(ACT_FIND,    32'h0000_0005, 32'h0,         8'd0);
        send_command(ACT_FIND,    32'h0000_0000, 32'h0,         8'd0);
        send_command(ACT_FIND,    32'hFFFF_FFFE, 32'h0,         8'd0);
        send_command(ACT_FIND,    32'hFFFF_FFFF, 32'h0,         8'd0);
        send_command(ACT_FIND,    32'h0000_0006, 32'h0,         8'd0);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd255);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd5);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd1);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd3);
        send_command(ACT_DEL,     32'h0,         32'h0,         8'd0);
        send_command(ACT_FIND,    32'h0000_0005, 32'h0,         8'd0);
        send_command(ACT_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    endtask

    initial
    begin
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (i = 0; i < RANDOM_CMDS; i++)
        begin
            // Idling pattern: receiver-heavy, then sender-heavy, then none.
            if (i == RANDOM_CMDS / 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 37;
            end
            else if (i == 2 * RANDOM_CMDS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_command(i);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d adds (%0d refused full, %0d reserved key), %0d finds",
                 sb.adds, sb.full_refusals, sb.reserved_refusals, sb.finds);
        $display("(%0d hits, %0d misses), %0d deletes (%0d bad position), peak fill %0d",
                 sb.hits, sb.misses, sb.deletes, sb.bad_positions, sb.peak_fill);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sorted_key_value_table_top.f
+incdir+sv
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/sorted_key_value_table_top.sv
bench/sorted_key_value_table_top_test.sv
